### design/bec_pkg.sv
// Shared constants, codes and types of the boolean expression syntax checker.
`default_nettype none

package bec_pkg;

    // Variable table geometry
    localparam int MAX_VARS = 8;
    localparam int CNT_W    = $clog2(MAX_VARS + 1);
    localparam int IDX_W    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam logic [CNT_W-1:0] MAX_SLOT = CNT_W'(MAX_VARS);

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int VAR_W    = 4;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 9;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 9'd511;

    // Register port
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_OPEN  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CLOSE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AND   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OR    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NOT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FALSE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TRUE  = 3'd6;

    localparam logic [CHAR_W-1:0] RST_OPEN  = 8'd40;
    localparam logic [CHAR_W-1:0] RST_CLOSE = 8'd41;
    localparam logic [CHAR_W-1:0] RST_AND   = 8'd42;
    localparam logic [CHAR_W-1:0] RST_OR    = 8'd43;
    localparam logic [CHAR_W-1:0] RST_NOT   = 8'd47;
    localparam logic [CHAR_W-1:0] RST_FALSE = 8'd48;
    localparam logic [CHAR_W-1:0] RST_TRUE  = 8'd49;

    typedef enum logic [STATUS_W-1:0] {
        ERR_NONE    = 3'd0,
        ERR_BRACKET = 3'd1,
        ERR_VARS    = 3'd2,
        ERR_OPER    = 3'd3,
        ERR_NOT     = 3'd4,
        ERR_LAST    = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        KIND_OPERAND = 2'd0,
        KIND_BIN     = 2'd1,
        KIND_NOT     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CL_OPEN,
        CL_CLOSE,
        CL_BIN,
        CL_NOT,
        CL_CONST,
        CL_VAR
    } class_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Requests into the variable table
    typedef struct packed {
        logic              start;
        logic              clear;
        logic [CHAR_W-1:0] char_code;
    } tbl_req_t;

    // Answers from the variable table
    typedef struct packed {
        logic             done;
        logic             full;
        logic [CNT_W-1:0] slot;
        logic [CNT_W-1:0] count;
    } tbl_rsp_t;

endpackage

`default_nettype wire

### design/bec_var_table.sv
// Variable name table with a one-slot-per-cycle sequential lookup.
`default_nettype none

module bec_var_table
    import bec_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire tbl_req_t req,
    output tbl_rsp_t      rsp
);

    logic [CHAR_W-1:0] names_mem [MAX_VARS];

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  issue_idx_reg, issue_idx_next;
    logic              cmp_vld_reg;
    logic [CNT_W-1:0]  cmp_idx_reg;
    logic [CHAR_W-1:0] rd_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg;
    logic              full_reg, full_next;
    logic [CNT_W-1:0]  slot_reg, slot_next;

    logic match;
    logic issue;
    logic finish_hit;
    logic finish_miss;
    logic add;

    // Filled slots are contiguous from zero, so the count marks which are valid
    always_comb begin
        match       = cmp_vld_reg && (rd_reg == req.char_code);
        issue       = busy_reg && !match && (issue_idx_reg < count_reg);
        finish_hit  = busy_reg && match;
        finish_miss = busy_reg && !match && (issue_idx_reg == count_reg);
        add         = finish_miss && (count_reg < MAX_SLOT);

        busy_next = busy_reg;
        if (req.start) begin
            busy_next = 1'b1;
        end else if (finish_hit || finish_miss) begin
            busy_next = 1'b0;
        end

        issue_idx_next = issue_idx_reg;
        if (req.start) begin
            issue_idx_next = '0;
        end else if (issue) begin
            issue_idx_next = issue_idx_reg + 1'b1;
        end

        count_next = count_reg;
        if (req.clear) begin
            count_next = '0;
        end else if (add) begin
            count_next = count_reg + 1'b1;
        end

        slot_next = slot_reg;
        full_next = full_reg;
        if (finish_hit) begin
            slot_next = cmp_idx_reg;
            full_next = 1'b0;
        end else if (finish_miss) begin
            slot_next = add ? count_reg : MAX_SLOT;
            full_next = !add;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cmp_vld_reg <= 1'b0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            cmp_vld_reg <= issue;
            count_reg   <= count_next;
            done_reg    <= finish_hit || finish_miss;
        end
    end

    always_ff @(posedge aclk) begin
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= issue_idx_reg;
        slot_reg      <= slot_next;
        full_reg      <= full_next;
    end

    // Name store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (add) begin
            names_mem[count_reg[IDX_W-1:0]] <= req.char_code;
        end
        if (issue) begin
            rd_reg <= names_mem[issue_idx_reg[IDX_W-1:0]];
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.full  = full_reg;
    assign rsp.slot  = slot_reg;
    assign rsp.count = count_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_SLOT)
        else $error("variable count beyond table size");
`endif

endmodule

`default_nettype wire

### design/boolean_expression_syntax_checker.sv
// Top level of the boolean expression syntax checker: registers, sequencer, result word.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-----------------------------------------
//  s_      | in  | s_tvalid / s_tready        | s_tdata[7:0] char_code, s_tlast is_last
//  m_      | out | m_tvalid / m_tready        | m_tdata status, var_count, var_slot;
//          |     |                            | m_tlast done_res
//  apb     | in  | psel, penable, pwrite      | paddr[4:2] register, pwdata[7:0] symbol
//
// An operator, bracket or constant word, and any word under an error in force,
// goes from accept through the evaluate, scan and done states to its result.
// A variable word stays in the scan state until the table lookup ends: on a hit
// in slot k, or, when the word is new or the table is full, after the N names
// already in the table (at most MAX_VARS) are passed; the one compare of the
// table lookup visits one stored name per cycle.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register and the next word is taken meanwhile.
// Reset is synchronous, active low; it clears the expression state and loads
// the default symbol codes.
`default_nettype none

module boolean_expression_syntax_checker
    import bec_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] char_code
    input  wire logic              s_tlast,   // is_last

    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // [2:0] status, [6:3] var_count, [10:7] var_slot
    output logic                   m_tlast,   // done_res

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // ---------------------------------------------------------------
    // Symbol registers
    // ---------------------------------------------------------------
    logic [CHAR_W-1:0] open_sym_reg, close_sym_reg, and_sym_reg, or_sym_reg;
    logic [CHAR_W-1:0] not_sym_reg, false_sym_reg, true_sym_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_sym_reg  <= RST_OPEN;
            close_sym_reg <= RST_CLOSE;
            and_sym_reg   <= RST_AND;
            or_sym_reg    <= RST_OR;
            not_sym_reg   <= RST_NOT;
            false_sym_reg <= RST_FALSE;
            true_sym_reg  <= RST_TRUE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_OPEN:  open_sym_reg  <= pwdata[CHAR_W-1:0];
                REG_CLOSE: close_sym_reg <= pwdata[CHAR_W-1:0];
                REG_AND:   and_sym_reg   <= pwdata[CHAR_W-1:0];
                REG_OR:    or_sym_reg    <= pwdata[CHAR_W-1:0];
                REG_NOT:   not_sym_reg   <= pwdata[CHAR_W-1:0];
                REG_FALSE: false_sym_reg <= pwdata[CHAR_W-1:0];
                REG_TRUE:  true_sym_reg  <= pwdata[CHAR_W-1:0];
                default: ;  // unmapped address, drop the write
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OPEN:  prdata = {{(DATA_W-CHAR_W){1'b0}}, open_sym_reg};
            REG_CLOSE: prdata = {{(DATA_W-CHAR_W){1'b0}}, close_sym_reg};
            REG_AND:   prdata = {{(DATA_W-CHAR_W){1'b0}}, and_sym_reg};
            REG_OR:    prdata = {{(DATA_W-CHAR_W){1'b0}}, or_sym_reg};
            REG_NOT:   prdata = {{(DATA_W-CHAR_W){1'b0}}, not_sym_reg};
            REG_FALSE: prdata = {{(DATA_W-CHAR_W){1'b0}}, false_sym_reg};
            REG_TRUE:  prdata = {{(DATA_W-CHAR_W){1'b0}}, true_sym_reg};
            default:   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer and expression state
    // ---------------------------------------------------------------
    state_t state_reg, state_next;

    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    class_t             class_reg, class_next;
    logic               end_op_reg, end_op_next;
    logic               scan_start_reg;

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    kind_t              kind_reg, kind_next;
    err_t               sticky_reg, sticky_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [15:0]        m_tdata_reg;
    logic               m_tlast_reg;

    tbl_req_t           tbl_req;
    tbl_rsp_t           tbl_rsp;

    logic               accept;
    logic               out_free;
    logic               commit;
    logic               var_path;

    // datapath results for the word in hand
    err_t               step_err;
    logic [DEPTH_W-1:0] step_depth;
    kind_t              step_kind;
    err_t               status_n;
    logic [CNT_W-1:0]   slot_n;
    logic [15:0]        word_n;

    bec_var_table u_var_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rsp     (tbl_rsp)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign var_path = (sticky_reg == ERR_NONE) && (class_reg == CL_VAR);

    // Decode the held character; open wins over close, close over and/or, and so on
    always_comb begin
        if (char_reg == open_sym_reg) begin
            class_next = CL_OPEN;
        end else if (char_reg == close_sym_reg) begin
            class_next = CL_CLOSE;
        end else if (char_reg == and_sym_reg || char_reg == or_sym_reg) begin
            class_next = CL_BIN;
        end else if (char_reg == not_sym_reg) begin
            class_next = CL_NOT;
        end else if (char_reg == false_sym_reg || char_reg == true_sym_reg) begin
            class_next = CL_CONST;
        end else begin
            class_next = CL_VAR;
        end
        // the end check looks at the raw codes, not at the decoded class
        end_op_next = (char_reg == and_sym_reg) || (char_reg == or_sym_reg)
                   || (char_reg == not_sym_reg);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                // classification lands in class_reg at this edge; check it next cycle
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!var_path || tbl_rsp.done) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready          = 1'b0;
        tbl_req.start     = 1'b0;
        tbl_req.clear     = 1'b0;
        tbl_req.char_code = char_reg;
        commit            = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EVAL: ;
            ST_SCAN: begin
                // launch the lookup on the first scan cycle only
                tbl_req.start = var_path && scan_start_reg;
            end
            ST_DONE: begin
                commit        = out_free;
                tbl_req.clear = out_free && last_reg;
            end
            default: ;
        endcase
    end

    // Apply one word to the expression state
    always_comb begin
        step_err   = ERR_NONE;
        step_depth = depth_reg;
        step_kind  = kind_reg;
        unique case (class_reg)
            CL_OPEN: begin
                if (depth_reg >= DEPTH_MAX) begin
                    step_err = ERR_BRACKET;
                end else begin
                    step_depth = depth_reg + 1'b1;
                    step_kind  = KIND_OPERAND;
                end
            end
            CL_CLOSE: begin
                if (depth_reg == '0) step_err = ERR_BRACKET;
                else                 step_depth = depth_reg - 1'b1;
            end
            CL_BIN: begin
                if (kind_reg != KIND_OPERAND) step_err = ERR_OPER;
                else                          step_kind = KIND_BIN;
            end
            CL_NOT: begin
                if (kind_reg == KIND_NOT) step_err = ERR_NOT;
                else                      step_kind = KIND_NOT;
            end
            CL_CONST: step_kind = KIND_OPERAND;
            CL_VAR: begin
                if (tbl_rsp.full) step_err = ERR_VARS;
                else              step_kind = KIND_OPERAND;
            end
            default: ;
        endcase

        // closing checks on the final word
        if (last_reg && step_err == ERR_NONE) begin
            if (step_depth != '0) step_err = ERR_BRACKET;
            else if (end_op_reg)  step_err = ERR_LAST;
        end

        // an error in force freezes everything and is repeated
        if (sticky_reg != ERR_NONE) begin
            status_n = sticky_reg;
            slot_n   = MAX_SLOT;
        end else begin
            status_n = step_err;
            slot_n   = (class_reg == CL_VAR) ? tbl_rsp.slot : MAX_SLOT;
        end

        word_n = {5'd0, VAR_W'(slot_n), VAR_W'(tbl_rsp.count), status_n};

        depth_next  = depth_reg;
        kind_next   = kind_reg;
        sticky_next = sticky_reg;
        if (commit) begin
            if (last_reg) begin
                depth_next  = '0;
                kind_next   = KIND_OPERAND;
                sticky_next = ERR_NONE;
            end else if (sticky_reg == ERR_NONE) begin
                sticky_next = step_err;
                if (step_err == ERR_NONE) begin
                    depth_next = step_depth;
                    kind_next  = step_kind;
                end
            end
        end

        m_tvalid_next = m_tvalid_reg;
        if (commit)        m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            depth_reg      <= '0;
            kind_reg       <= KIND_OPERAND;
            sticky_reg     <= ERR_NONE;
            m_tvalid_reg   <= 1'b0;
            scan_start_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            depth_reg      <= depth_next;
            kind_reg       <= kind_next;
            sticky_reg     <= sticky_next;
            m_tvalid_reg   <= m_tvalid_next;
            // mark the first scan cycle, which always follows the evaluate cycle
            scan_start_reg <= (state_reg == ST_EVAL);
        end
    end

    // Payload registers: hold the word in hand and the pending result
    always_ff @(posedge aclk) begin
        if (accept) begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (state_reg == ST_EVAL) begin
            class_reg  <= class_next;
            end_op_reg <= end_op_next;
        end
        if (commit) begin
            m_tdata_reg <= word_n;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    a_tbl_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_rsp.done |-> state_reg == ST_SCAN)
        else $error("table answer outside scan");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && last_reg) |=>
            (depth_reg == '0 && sticky_reg == ERR_NONE && kind_reg == KIND_OPERAND))
        else $error("expression state not cleared after final word");

    a_slot_means_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast && m_tdata[10:7] != VAR_W'(MAX_VARS))
            |-> m_tdata[2:0] == ERR_NONE)
        else $error("table slot reported together with an error");
`endif

endmodule

`default_nettype wire
